// File: rtl/vkl_pkg.sv
// vkl_pkg: shared types and constants for the value-keyed list engine
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package vkl_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND     = 3'd0,
        ACT_REPLACE    = 3'd1,
        ACT_INS_BEFORE = 3'd2,
        ACT_INS_AFTER  = 3'd3,
        ACT_DELETE     = 3'd4,
        ACT_READ       = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic append;
        logic replace;
        logic ins_before;
        logic ins_after;
        logic del;
    } cell_ctl_t;

endpackage

// File: rtl/vkl_req_if.sv
// vkl_req_if: request channel, valid/ready handshake with request payload
// depends on vkl_pkg for field widths
`timescale 1ns / 1ps

interface vkl_req_if;
    logic                         valid;
    logic                         ready;
    logic [vkl_pkg::ACTION_W-1:0] action;
    logic [vkl_pkg::VALUE_W-1:0]  key;
    logic [vkl_pkg::VALUE_W-1:0]  new_value;
    logic [vkl_pkg::POS_W-1:0]    position;

    modport source (output valid, action, key, new_value, position, input ready);
    modport sink (input valid, action, key, new_value, position, output ready);
endinterface

// File: rtl/vkl_rsp_if.sv
// vkl_rsp_if: response channel, valid/ready handshake with result payload
// depends on vkl_pkg for field widths
`timescale 1ns / 1ps

interface vkl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [vkl_pkg::STATUS_W-1:0] status;
    logic [vkl_pkg::INDEX_W-1:0]  found_index;
    logic [vkl_pkg::COUNT_W-1:0]  entry_count;
    logic [vkl_pkg::VALUE_W-1:0]  read_value;

    modport source (output valid, status, found_index, entry_count, read_value, input ready);
    modport sink (input valid, status, found_index, entry_count, read_value, output ready);
endinterface

// File: rtl/vkl_cell.sv
// vkl_cell: one list slot; holds an entry and its match flag, shifts with neighbors
// depends on vkl_pkg for the control struct and widths
`timescale 1ns / 1ps

module vkl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vkl_pkg::cell_ctl_t          ctl,
    input  logic [vkl_pkg::VALUE_W-1:0] key,
    input  logic [vkl_pkg::VALUE_W-1:0] new_value,
    input  logic                        live,
    input  logic                        at_count,
    input  logic                        at_pos,
    input  logic                        prefix_in,
    input  logic                        prev_first,
    input  logic [vkl_pkg::VALUE_W-1:0] prev_entry,
    input  logic [vkl_pkg::VALUE_W-1:0] next_entry,
    output logic [vkl_pkg::VALUE_W-1:0] entry,
    output logic                        prefix_out,
    output logic                        first,
    output logic [vkl_pkg::VALUE_W-1:0] rdata
);

    logic [vkl_pkg::VALUE_W-1:0] entry_reg;
    logic [vkl_pkg::VALUE_W-1:0] entry_next;
    logic                        match_reg;
    logic                        match_next;

    assign first      = match_reg & ~prefix_in;
    assign prefix_out = prefix_in | match_reg;
    assign entry      = entry_reg;
    assign rdata      = at_pos ? entry_reg : '0;

    always_comb
    begin
        match_next = match_reg;
        if (ctl.capture)
        begin
            match_next = live && (entry_reg == key);
        end
    end

    always_comb
    begin
        priority if (ctl.append && at_count)
        begin
            entry_next = new_value;
        end
        else if (ctl.replace && first)
        begin
            entry_next = new_value;
        end
        else if (ctl.ins_before && first)
        begin
            entry_next = new_value;
        end
        else if (ctl.ins_before && prefix_in)
        begin
            entry_next = prev_entry;
        end
        else if (ctl.ins_after && prev_first)
        begin
            entry_next = new_value;
        end
        else if (ctl.ins_after && prefix_in)
        begin
            entry_next = prev_entry;
        end
        else if (ctl.del && (first || prefix_in))
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

// File: rtl/value_keyed_list_engine_unit.sv
// value_keyed_list_engine_unit: ordered list of unsigned words kept in a row of cells
// depends on vkl_pkg, vkl_req_if, vkl_rsp_if and vkl_cell
//
// usage
//   req channel carries one request beat: action, key, new_value, position
//   rsp channel returns exactly one result beat per request: status,
//   found_index, entry_count and read_value
//   on the accept edge every cell compares its entry with key and registers a
//   match flag; in the next cycle the first match ripples out along the cell
//   row, the cells shift or load in place and the result is registered onto rsp
//   no new request is taken until the compare-then-update pass through the
//   cell row is done
//   a new request is taken while the previous result is being drained
//   when rsp stalls, the result is held and req stays not ready
//   reset empties the list (count zero) and drops any pending result;
//   entry contents are not cleared and only slots below count are ever read
`timescale 1ns / 1ps

module value_keyed_list_engine_unit #(
    parameter int CAPACITY = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    vkl_req_if.sink    req,
    vkl_rsp_if.source  rsp
);

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int IW7  = (IDXW > vkl_pkg::INDEX_W) ? IDXW : vkl_pkg::INDEX_W;
    localparam int CW8  = (CNTW > vkl_pkg::COUNT_W) ? CNTW : vkl_pkg::COUNT_W;
    localparam int PCW  = (CNTW > vkl_pkg::POS_W) ? CNTW : vkl_pkg::POS_W;

    vkl_pkg::state_t             state_reg;
    vkl_pkg::state_t             state_next;
    logic [CNTW-1:0]             count_reg;
    logic [CNTW-1:0]             count_next;
    vkl_pkg::action_t            act_reg;
    logic [vkl_pkg::VALUE_W-1:0] value_reg;
    logic [vkl_pkg::POS_W-1:0]   pos_reg;

    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    vkl_pkg::status_t            status_reg;
    vkl_pkg::status_t            status_next;
    logic [vkl_pkg::INDEX_W-1:0] found_reg;
    logic [vkl_pkg::COUNT_W-1:0] count_out_reg;
    logic [vkl_pkg::VALUE_W-1:0] rval_reg;
    logic [vkl_pkg::VALUE_W-1:0] rval_next;
    logic [IDXW-1:0]             fidx;
    logic [IW7-1:0]              fidx_wide;
    logic [CW8-1:0]              count_wide;

    logic                        accept;
    logic                        hit;
    logic                        full;
    logic                        pos_ok;
    vkl_pkg::cell_ctl_t          ctl;

    logic [CAPACITY:0]           prefix;
    logic [CAPACITY-1:0]         first_vec;
    logic [CAPACITY-1:0]         live_vec;
    logic [CAPACITY-1:0]         at_count_vec;
    logic [CAPACITY-1:0]         at_pos_vec;
    logic [vkl_pkg::VALUE_W-1:0] entry_arr [CAPACITY];
    logic [vkl_pkg::VALUE_W-1:0] rdata_arr [CAPACITY];
    logic [vkl_pkg::VALUE_W-1:0] rdata_or;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == vkl_pkg::S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign hit       = prefix[CAPACITY];
    assign full      = (count_reg == CNTW'(CAPACITY));
    assign pos_ok    = (PCW'(pos_reg) < PCW'(count_reg));
    assign prefix[0] = 1'b0;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live_vec[i]     = (CNTW'(i) < count_reg);
            at_count_vec[i] = (CNTW'(i) == count_reg);
            at_pos_vec[i]   = (PCW'(pos_reg) == PCW'(i));
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [vkl_pkg::VALUE_W-1:0] prev_e;
            logic [vkl_pkg::VALUE_W-1:0] next_e;
            logic                        prev_f;

            if (g == 0)
            begin : g_head
                assign prev_e = entry_arr[0];
                assign prev_f = 1'b0;
            end
            else
            begin : g_body
                assign prev_e = entry_arr[g-1];
                assign prev_f = first_vec[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign next_e = entry_arr[g];
            end
            else
            begin : g_mid
                assign next_e = entry_arr[g+1];
            end

            vkl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (req.key),
                .new_value  (value_reg),
                .live       (live_vec[g]),
                .at_count   (at_count_vec[g]),
                .at_pos     (at_pos_vec[g]),
                .prefix_in  (prefix[g]),
                .prev_first (prev_f),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (entry_arr[g]),
                .prefix_out (prefix[g+1]),
                .first      (first_vec[g]),
                .rdata      (rdata_arr[g])
            );
        end
    endgenerate

    always_comb
    begin
        fidx     = '0;
        rdata_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_vec[i])
            begin
                fidx = fidx | IDXW'(i);
            end
            rdata_or = rdata_or | rdata_arr[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vkl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = vkl_pkg::S_EXEC;
                end
            end
            vkl_pkg::S_EXEC:
            begin
                state_next = vkl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = vkl_pkg::S_IDLE;
            end
        endcase
    end

    // cell controls and result
    always_comb
    begin
        ctl         = '0;
        ctl.capture = accept;
        status_next = vkl_pkg::ST_OK;
        rval_next   = '0;
        count_next  = count_reg;
        fidx_wide   = '0;
        if (state_reg == vkl_pkg::S_EXEC)
        begin
            unique case (act_reg)
                vkl_pkg::ACT_APPEND:
                begin
                    if (full)
                    begin
                        status_next = vkl_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.append = 1'b1;
                        count_next = count_reg + CNTW'(1);
                    end
                end
                vkl_pkg::ACT_REPLACE, vkl_pkg::ACT_INS_BEFORE,
                vkl_pkg::ACT_INS_AFTER, vkl_pkg::ACT_DELETE:
                begin
                    if (!hit)
                    begin
                        status_next = vkl_pkg::ST_MISSING;
                    end
                    else
                    begin
                        fidx_wide = IW7'(fidx);
                        if (act_reg == vkl_pkg::ACT_REPLACE)
                        begin
                            ctl.replace = 1'b1;
                        end
                        else if (act_reg == vkl_pkg::ACT_DELETE)
                        begin
                            ctl.del    = 1'b1;
                            count_next = count_reg - CNTW'(1);
                        end
                        else if (full)
                        begin
                            status_next = vkl_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.ins_before = (act_reg == vkl_pkg::ACT_INS_BEFORE);
                            ctl.ins_after  = (act_reg == vkl_pkg::ACT_INS_AFTER);
                            count_next     = count_reg + CNTW'(1);
                        end
                    end
                end
                vkl_pkg::ACT_READ:
                begin
                    if (pos_ok)
                    begin
                        rval_next = rdata_or;
                    end
                    else
                    begin
                        status_next = vkl_pkg::ST_RANGE;
                    end
                end
                default:
                begin
                    status_next = vkl_pkg::ST_OK;
                end
            endcase
        end
        count_wide = CW8'(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (state_reg == vkl_pkg::S_EXEC)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vkl_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= vkl_pkg::action_t'(req.action);
            value_reg <= req.new_value;
            pos_reg   <= req.position;
        end
        if (state_reg == vkl_pkg::S_EXEC)
        begin
            status_reg    <= status_next;
            found_reg     <= fidx_wide[vkl_pkg::INDEX_W-1:0];
            rval_reg      <= rval_next;
            count_out_reg <= count_wide[vkl_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = found_reg;
    assign rsp.entry_count = count_out_reg;
    assign rsp.read_value  = rval_reg;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == vkl_pkg::S_IDLE))
        else $error("request taken outside idle");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 rsp.valid)
        else $error("no result two cycles after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(CAPACITY))
        else $error("count above capacity");

    a_single_first: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one first match");
`endif

endmodule
